### sv/poae_pkg.sv
`default_nettype none

package poae_pkg;

	// Word and field geometry.
	localparam int WORD_BITS = 16;
	localparam int FIELD_MAX = 16;

	// Instruction word layout: count at the top, then the opcodes, then the width.
	localparam int CNT_SHIFT = 29;
	localparam int HDR_SKIP  = 3;
	localparam int OP_BITS   = 2;
	localparam int WID_SHIFT = 28;
	localparam int OP_TOP    = 31 - HDR_SKIP;
	localparam int WID_BASE  = WID_SHIFT - HDR_SKIP;

	// Depth of the operand queue between the front and the back.
	localparam int QUEUE_DEPTH = 2;

	typedef enum logic [1:0] {
		OP_ADD = 2'd0,
		OP_SUB = 2'd1,
		OP_MUL = 2'd2,
		OP_DIV = 2'd3
	} op_t;

	typedef enum logic [1:0] {
		EX_IDLE,
		EX_DIV,
		EX_EMIT
	} ex_state_t;

	// One command transfer.
	typedef struct packed {
		logic        func;
		logic [31:0] instruction;
		logic [15:0] data_word;
	} poae_in_t;

	// One result transfer.
	typedef struct packed {
		logic signed [31:0] result;
		logic               div_by_zero;
	} poae_out_t;

	// One finished operand, queued for the back end.
	typedef struct packed {
		logic [FIELD_MAX-1:0] operand;
		op_t                  opcode;
		logic                 first;
		logic                 last;
	} poae_entry_t;

endpackage

`default_nettype wire

### sv/poae_queue.sv
`default_nettype none

module poae_queue
	import poae_pkg::*;
(
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        push,
	input  wire poae_entry_t push_entry,
	output logic             full,
	input  wire logic        pop,
	output poae_entry_t      pop_entry,
	output logic             not_empty
);

	localparam int PTR_W = $clog2(QUEUE_DEPTH);
	localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);

	poae_entry_t        entries_q [QUEUE_DEPTH];
	logic [PTR_W-1:0]   wr_ptr_q;
	logic [PTR_W-1:0]   rd_ptr_q;
	logic [CNT_W-1:0]   count_q;

	assign full      = (count_q == CNT_W'(QUEUE_DEPTH));
	assign not_empty = (count_q != '0);
	assign pop_entry = entries_q[rd_ptr_q];

	// Entry storage is written at the write pointer only.
	always_ff @(posedge clk) begin
		if (push) begin
			entries_q[wr_ptr_q] <= push_entry;
		end
	end

	// Pointers and fill count.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= (wr_ptr_q == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
			end
			if (pop) begin
				rd_ptr_q <= (rd_ptr_q == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
			end
			case ({push, pop})
				2'b10:   count_q <= count_q + 1'b1;
				2'b01:   count_q <= count_q - 1'b1;
				default: count_q <= count_q;
			endcase
		end
	end

	a_no_push_full: assert property (@(posedge clk) disable iff (!arst_n) push |-> !full)
		else $error("operand queue overflow");
	a_no_pop_empty: assert property (@(posedge clk) disable iff (!arst_n) pop |-> not_empty)
		else $error("operand queue underflow");
	a_count_range: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= CNT_W'(QUEUE_DEPTH))
		else $error("operand queue count out of range");

endmodule

`default_nettype wire

### sv/poae_front.sv
`default_nettype none

module poae_front
	import poae_pkg::*;
#(
	parameter int MAX_OPS = 8
) (
	input  wire logic     clk,
	input  wire logic     arst_n,
	input  wire logic     cmd_valid,
	output logic          cmd_stall,
	input  wire poae_in_t cmd,
	output logic          push,
	output poae_entry_t   push_entry,
	input  wire logic     full
);

	localparam int CNT_W = $clog2(MAX_OPS + 1);

	// Evaluation setup taken from the instruction word.
	op_t              ops_q [MAX_OPS];
	logic [CNT_W-1:0] total_q;
	logic [4:0]       width_q;

	// Operand assembly state.
	logic                 busy_q;
	logic [FIELD_MAX-1:0] bits_q;
	logic [4:0]           fill_q;
	logic [CNT_W-1:0]     idx_q;
	logic [WORD_BITS-1:0] word_q;
	logic [4:0]           rem_q;

	logic                 accept;
	logic [3:0]           n_dec;
	logic [4:0]           wid_sh;
	logic [3:0]           wid_field;
	logic [4:0]           need;
	logic [4:0]           take_n;
	logic [31:0]          take;
	logic [FIELD_MAX-1:0] bits_new;
	logic [WORD_BITS-1:0] word_new;
	logic                 complete;
	logic                 last_op;
	logic                 advance;

	// A data word is worked off before the next transfer is taken.
	assign cmd_stall = (rem_q != '0);
	assign accept    = cmd_valid && !cmd_stall;

	// Instruction decode: operand count and the position of the width field.
	assign n_dec     = {1'b0, cmd.instruction[31:CNT_SHIFT]} + 4'd1;
	assign wid_sh    = 5'(WID_BASE) - {n_dec, 1'b0};
	assign wid_field = 4'(cmd.instruction >> wid_sh);

	// Take as many bits as finish the operand or empty the word, whichever is fewer.
	assign need     = width_q - fill_q;
	assign take_n   = (rem_q < need) ? rem_q : need;
	assign take     = {16'd0, word_q} >> (5'(WORD_BITS) - take_n);
	assign bits_new = FIELD_MAX'(({16'd0, bits_q} << take_n) | take);
	assign word_new = WORD_BITS'({16'd0, word_q} << take_n);
	assign complete = ((fill_q + take_n) == width_q);
	assign last_op  = complete && (idx_q == total_q);
	assign advance  = busy_q && (rem_q != '0) && !(complete && full);

	assign push             = advance && complete;
	assign push_entry.operand = bits_new;
	assign push_entry.opcode  = ops_q[0];
	assign push_entry.first   = (idx_q == '0);
	assign push_entry.last    = last_op;

	// Opcode list: loaded from the instruction, shifted as operands consume it.
	always_ff @(posedge clk) begin
		if (accept && !cmd.func) begin
			for (int k = 0; k < MAX_OPS; k++) begin
				ops_q[k] <= op_t'(cmd.instruction[(OP_TOP - OP_BITS * k) -: OP_BITS]);
			end
			total_q <= (32'(n_dec) > MAX_OPS) ? CNT_W'(MAX_OPS) : CNT_W'(n_dec);
			width_q <= {1'b0, wid_field} + 5'd1;
		end else if (push && (idx_q != '0)) begin
			for (int k = 0; k < MAX_OPS - 1; k++) begin
				ops_q[k] <= ops_q[k + 1];
			end
		end
	end

	// Data word and partial operand payload.
	always_ff @(posedge clk) begin
		if (accept && cmd.func && busy_q) begin
			word_q <= cmd.data_word;
		end else if (advance) begin
			word_q <= word_new;
		end
		if (accept && !cmd.func) begin
			bits_q <= '0;
		end else if (advance) begin
			bits_q <= complete ? '0 : bits_new;
		end
	end

	// Assembly control.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			fill_q <= '0;
			idx_q  <= '0;
			rem_q  <= '0;
		end else if (accept) begin
			if (!cmd.func) begin
				busy_q <= 1'b1;
				fill_q <= '0;
				idx_q  <= '0;
			end else if (busy_q) begin
				rem_q <= 5'(WORD_BITS);
			end
		end else if (advance) begin
			if (complete) begin
				fill_q <= '0;
				idx_q  <= idx_q + 1'b1;
			end else begin
				fill_q <= fill_q + take_n;
			end
			if (last_op) begin
				busy_q <= 1'b0;
				rem_q  <= '0;
			end else begin
				rem_q <= rem_q - take_n;
			end
		end
	end

	a_rem_needs_busy: assert property (@(posedge clk) disable iff (!arst_n)
		(rem_q != '0) |-> busy_q)
		else $error("data bits pending while no evaluation is open");
	a_idx_bound: assert property (@(posedge clk) disable iff (!arst_n)
		busy_q |-> (idx_q <= total_q))
		else $error("operand index beyond operand count");
	a_last_ends: assert property (@(posedge clk) disable iff (!arst_n)
		(push && push_entry.last) |=> (!busy_q && (rem_q == '0)))
		else $error("evaluation still open after its last operand");

endmodule

`default_nettype wire

### sv/poae_exec.sv
`default_nettype none

module poae_exec
	import poae_pkg::*;
(
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        q_valid,
	input  wire poae_entry_t q_entry,
	output logic             q_pop,
	output logic             res_valid,
	input  wire logic        res_stall,
	output poae_out_t        res
);

	ex_state_t state_q;
	ex_state_t state_d;

	logic [31:0] acc_q;
	logic        err_q;
	logic        last_q;
	logic        neg_q;
	logic [15:0] divisor_q;
	logic [31:0] dq_q;
	logic [15:0] part_q;
	logic [4:0]  cnt_q;
	logic        res_valid_q;
	poae_out_t   res_q;

	logic        out_free;
	logic        load_out;
	logic        div_start;
	logic [16:0] trial;
	logic        ge;
	logic [16:0] diff;
	logic [31:0] quot;

	assign out_free  = !res_valid_q || !res_stall;
	assign div_start = (q_entry.opcode == OP_DIV) && !q_entry.first
		&& (q_entry.operand != '0);

	// Restoring divider step: one quotient bit per cycle.
	assign trial = {part_q, dq_q[31]};
	assign ge    = (trial >= {1'b0, divisor_q});
	assign diff  = trial - {1'b0, divisor_q};
	assign quot  = {dq_q[30:0], ge};

	// Sequencer: next state and handshake outputs.
	always_comb begin
		state_d  = state_q;
		q_pop    = 1'b0;
		load_out = 1'b0;
		case (state_q)
			EX_IDLE: begin
				if (q_valid) begin
					q_pop = 1'b1;
					if (div_start) begin
						state_d = EX_DIV;
					end else if (q_entry.last) begin
						state_d = EX_EMIT;
					end
				end
			end
			EX_DIV: begin
				if (cnt_q == '0) begin
					state_d = last_q ? EX_EMIT : EX_IDLE;
				end
			end
			EX_EMIT: begin
				if (out_free) begin
					load_out = 1'b1;
					state_d  = EX_IDLE;
				end
			end
			default: begin
				state_d = EX_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= EX_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	// Accumulator, flag and divider datapath.
	always_ff @(posedge clk) begin
		if (q_pop) begin
			last_q <= q_entry.last;
			if (q_entry.first) begin
				acc_q <= 32'(q_entry.operand);
				err_q <= 1'b0;
			end else begin
				case (q_entry.opcode)
					OP_ADD: acc_q <= acc_q + 32'(q_entry.operand);
					OP_SUB: acc_q <= acc_q - 32'(q_entry.operand);
					OP_MUL: acc_q <= 32'(acc_q * 32'(q_entry.operand));
					default: begin
						if (q_entry.operand == '0) begin
							err_q <= 1'b1;
						end else begin
							neg_q     <= acc_q[31];
							dq_q      <= acc_q[31] ? (32'd0 - acc_q) : acc_q;
							part_q    <= '0;
							divisor_q <= q_entry.operand;
							cnt_q     <= 5'd31;
						end
					end
				endcase
			end
		end else if (state_q == EX_DIV) begin
			part_q <= ge ? diff[15:0] : trial[15:0];
			dq_q   <= quot;
			cnt_q  <= cnt_q - 1'b1;
			if (cnt_q == '0) begin
				acc_q <= neg_q ? (32'd0 - quot) : quot;
			end
		end
	end

	// Output register: holds a result until the receiver takes it.
	always_ff @(posedge clk) begin
		if (load_out) begin
			res_q.result      <= acc_q;
			res_q.div_by_zero <= err_q;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			res_valid_q <= 1'b0;
		end else if (load_out) begin
			res_valid_q <= 1'b1;
		end else if (!res_stall) begin
			res_valid_q <= 1'b0;
		end
	end

	assign res_valid = res_valid_q;
	assign res       = res_q;

	a_pop_idle: assert property (@(posedge clk) disable iff (!arst_n)
		q_pop |-> ((state_q == EX_IDLE) && q_valid))
		else $error("operand taken while the unit was occupied");
	a_div_nonzero: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == EX_DIV) |-> (divisor_q != '0))
		else $error("divider running on a zero divisor");
	a_res_from_emit: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(res_valid_q) |-> ($past(state_q) == EX_EMIT))
		else $error("result presented outside the emit step");
	a_load_free: assert property (@(posedge clk) disable iff (!arst_n)
		load_out |-> out_free)
		else $error("result register overwritten while held");

endmodule

`default_nettype wire

### sv/packed_operand_alu_evaluator.sv
// Packed-operand evaluator.
// Command channel (cmd_valid, cmd_stall, cmd): func = 0 carries an instruction
// word that opens a new evaluation and drops any unfinished one; func = 1 carries
// a 16-bit data word of packed operands, ignored while no evaluation is open.
// Result channel (res_valid, res_stall, res): one transfer per evaluation, with
// the signed 32-bit accumulator and the divide-by-zero flag.
// After a data word's transfer, cmd_stall stays high while the front cuts the
// word into pieces, where a piece ends at an operand boundary or the end of the
// word: 1 to 16 pieces, 16 only for one-bit operands. The back end folds an add,
// subtract or multiply into the accumulator as it pops the operand, and runs the
// one-bit-per-cycle restoring divider for a division by a nonzero operand; a
// two-entry operand queue lets the front run ahead of it. With the back end free,
// the result goes through the emit state and the result register before
// res_valid rises, after the last operand or after the divider's last step.
// At reset no evaluation is open and the result register is empty. While
// res_stall is high the result holds; the back end then waits with the next
// result, the queue fills, and cmd_stall stays high once the front needs a slot.
`default_nettype none

module packed_operand_alu_evaluator
	import poae_pkg::*;
#(
	parameter int MAX_OPS = 8
) (
	input  wire logic     clk,
	input  wire logic     arst_n,
	input  wire logic     cmd_valid,
	output logic          cmd_stall,
	input  wire poae_in_t cmd,
	output logic          res_valid,
	input  wire logic     res_stall,
	output poae_out_t     res
);

	logic        push;
	poae_entry_t push_entry;
	logic        full;
	logic        pop;
	poae_entry_t pop_entry;
	logic        not_empty;

	// Front end: decodes instructions and cuts data words into operands.
	poae_front #(
		.MAX_OPS(MAX_OPS)
	) u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.cmd_valid (cmd_valid),
		.cmd_stall (cmd_stall),
		.cmd       (cmd),
		.push      (push),
		.push_entry(push_entry),
		.full      (full)
	);

	// Operand queue between the two ends.
	poae_queue u_queue (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (push),
		.push_entry(push_entry),
		.full      (full),
		.pop       (pop),
		.pop_entry (pop_entry),
		.not_empty (not_empty)
	);

	// Back end: folds operands into the accumulator and emits the result.
	poae_exec u_exec (
		.clk      (clk),
		.arst_n   (arst_n),
		.q_valid  (not_empty),
		.q_entry  (pop_entry),
		.q_pop    (pop),
		.res_valid(res_valid),
		.res_stall(res_stall),
		.res      (res)
	);

endmodule

`default_nettype wire
